// ----- design/pol_pkg.sv -----
// Shared operation and status codes for the positional ordered list.
package pol_pkg;

  localparam int ModeW   = 3;
  localparam int PosW    = 6;
  localparam int ValW    = 32;
  localparam int StatusW = 2;
  localparam int CountW  = 6;

  localparam logic [ModeW-1:0] ModeInsFront = 3'd0;
  localparam logic [ModeW-1:0] ModeInsBack  = 3'd1;
  localparam logic [ModeW-1:0] ModeInsAt    = 3'd2;
  localparam logic [ModeW-1:0] ModeDelFront = 3'd3;
  localparam logic [ModeW-1:0] ModeDelBack  = 3'd4;
  localparam logic [ModeW-1:0] ModeDelAt    = 3'd5;
  localparam logic [ModeW-1:0] ModeDump     = 3'd6;

  localparam logic [StatusW-1:0] StOk     = 2'd0;
  localparam logic [StatusW-1:0] StBadPos = 2'd1;
  localparam logic [StatusW-1:0] StEmpty  = 2'd2;
  localparam logic [StatusW-1:0] StFull   = 2'd3;

endpackage

// ----- design/pol_mem.sv -----
// Entry storage: one write port and one registered read port.
module pol_mem #(
  parameter int Depth = 32,
  parameter int Width = 32,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/positional_ordered_list.sv -----
// Top level of the positional ordered list with its shifting sequencer.
//
// The block keeps an ordered list of up to CAPACITY values in a single-port
// style memory. Each input item on the in channel (valid/ready) carries a
// mode, a 1-based position and a value. Results leave on the out channel
// (valid/ready) from an output register.
// Rejected requests, inserts at the back and deletes of the last entry
// finish in the accept cycle; their result is registered and visible in
// the next cycle. An insert or delete at another position moves each
// later entry by one slot, reading it (SInsRd or SDelRd) and then
// writing it (SInsWr or SDelWr); an insert then places the new value
// (SInsPut), and both post the result from SDone.
// A dump reads each entry (SDumpRd) and posts it as one item (SDumpOut),
// the last one marked; an empty list dumps as one item with status empty.
// The input is not ready while an item is in progress. When the receiver
// stalls, the sequencer holds before loading the output register, and a
// new input item is taken only once the output register can be loaded.
// Reset empties the list at once; entry contents need no clearing.
module positional_ordered_list
  import pol_pkg::*;
#(
  parameter int CAPACITY   = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ModeW-1:0]   mode_i,
  input  logic [PosW-1:0]    position_i,
  input  logic [ValW-1:0]    in_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StatusW-1:0] status_o,
  output logic [CountW-1:0]  entry_count_o,
  output logic [ValW-1:0]    out_value_o,
  output logic [CountW-1:0]  out_index_o,
  output logic               is_last_o
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);

  localparam logic [3:0] SIdle    = 4'd0;
  localparam logic [3:0] SInsRd   = 4'd1;
  localparam logic [3:0] SInsWr   = 4'd2;
  localparam logic [3:0] SInsPut  = 4'd3;
  localparam logic [3:0] SDelRd   = 4'd4;
  localparam logic [3:0] SDelWr   = 4'd5;
  localparam logic [3:0] SDumpRd  = 4'd6;
  localparam logic [3:0] SDumpOut = 4'd7;
  localparam logic [3:0] SDone    = 4'd8;

  logic [3:0]            state_q, state_d;
  logic [CntW-1:0]       occ_q, occ_d;
  logic [CntW-1:0]       idx_q, idx_d;
  logic [CntW-1:0]       slot_q, slot_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;

  logic                  out_valid_q;
  logic [StatusW-1:0]    status_q, status_d;
  logic [CountW-1:0]     count_q, count_d;
  logic [ValW-1:0]       oval_q, oval_d;
  logic [CountW-1:0]     oidx_q, oidx_d;
  logic                  last_q, last_d;
  logic                  out_load;

  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;

  logic                  out_free;
  logic                  in_fire;
  logic [7:0]            pos_w, occ_w, slot_w;
  logic [63:0]           in_ext, rd_ext;
  logic [DATA_WIDTH-1:0] in_val;
  logic [CntW:0]         idx_x, occ_x, slot_x;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == SIdle) && out_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_w  = 8'(position_i);
  assign occ_w  = 8'(occ_q);
  assign in_ext = 64'(in_value_i);
  assign in_val = in_ext[DATA_WIDTH-1:0];
  assign rd_ext = 64'(mem_rdata);
  assign idx_x  = {1'b0, idx_q};
  assign occ_x  = {1'b0, occ_q};
  assign slot_x = {1'b0, slot_q};

  always_comb begin
    unique case (mode_i)
      ModeInsBack: slot_w = occ_w;
      ModeInsAt,
      ModeDelAt:   slot_w = pos_w - 8'd1;
      ModeDelBack: slot_w = occ_w - 8'd1;
      default:     slot_w = 8'd0;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    idx_d     = idx_q;
    slot_d    = slot_q;
    val_d     = val_q;
    out_load  = 1'b0;
    status_d  = StOk;
    count_d   = CountW'(occ_q);
    oval_d    = '0;
    oidx_d    = '0;
    last_d    = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      SIdle: begin
        if (in_fire) begin
          slot_d = CntW'(slot_w);
          val_d  = in_val;
          idx_d  = occ_q;
          unique case (mode_i)
            ModeInsFront, ModeInsBack, ModeInsAt: begin
              if (mode_i == ModeInsAt && (pos_w == 8'd0 || pos_w > occ_w + 8'd1)) begin
                out_load = 1'b1;
                status_d = StBadPos;
              end else if (occ_w >= 8'(CAPACITY)) begin
                out_load = 1'b1;
                status_d = StFull;
              end else if (slot_w == occ_w) begin
                mem_we    = 1'b1;
                mem_waddr = AddrW'(slot_w);
                mem_wdata = in_val;
                occ_d     = occ_q + 1'b1;
                out_load  = 1'b1;
                count_d   = CountW'(occ_d);
              end else begin
                state_d = SInsRd;
              end
            end
            ModeDelFront, ModeDelBack, ModeDelAt: begin
              if (occ_w == 8'd0) begin
                out_load = 1'b1;
                status_d = StEmpty;
              end else if (mode_i == ModeDelAt && (pos_w == 8'd0 || pos_w > occ_w)) begin
                out_load = 1'b1;
                status_d = StBadPos;
              end else if (slot_w + 8'd1 == occ_w) begin
                occ_d    = occ_q - 1'b1;
                out_load = 1'b1;
                count_d  = CountW'(occ_d);
              end else begin
                idx_d   = CntW'(slot_w);
                state_d = SDelRd;
              end
            end
            ModeDump: begin
              if (occ_w == 8'd0) begin
                out_load = 1'b1;
                status_d = StEmpty;
              end else begin
                idx_d   = '0;
                state_d = SDumpRd;
              end
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      SInsRd: begin
        mem_re    = 1'b1;
        mem_raddr = AddrW'(idx_q - 1'b1);
        state_d   = SInsWr;
      end
      SInsWr: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(idx_q);
        idx_d     = idx_q - 1'b1;
        if (idx_x == slot_x + 1'b1) begin
          state_d = SInsPut;
        end else begin
          state_d = SInsRd;
        end
      end
      SInsPut: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(slot_q);
        mem_wdata = val_q;
        occ_d     = occ_q + 1'b1;
        state_d   = SDone;
      end
      SDelRd: begin
        mem_re    = 1'b1;
        mem_raddr = AddrW'(idx_q + 1'b1);
        state_d   = SDelWr;
      end
      SDelWr: begin
        mem_we    = 1'b1;
        mem_waddr = AddrW'(idx_q);
        idx_d     = idx_q + 1'b1;
        if (idx_x + 2'd2 == occ_x) begin
          occ_d   = occ_q - 1'b1;
          state_d = SDone;
        end else begin
          state_d = SDelRd;
        end
      end
      SDumpRd: begin
        mem_re    = 1'b1;
        mem_raddr = AddrW'(idx_q);
        state_d   = SDumpOut;
      end
      SDumpOut: begin
        if (out_free) begin
          out_load = 1'b1;
          oval_d   = rd_ext[ValW-1:0];
          oidx_d   = CountW'(idx_x + 1'b1);
          last_d   = (idx_x + 1'b1 == occ_x);
          idx_d    = idx_q + 1'b1;
          state_d  = last_d ? SIdle : SDumpRd;
        end
      end
      SDone: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    slot_q <= slot_d;
    val_q  <= val_d;
    if (out_load) begin
      status_q <= status_d;
      count_q  <= count_d;
      oval_q   <= oval_d;
      oidx_q   <= oidx_d;
      last_q   <= last_d;
    end
  end

  pol_mem #(
    .Depth(CAPACITY),
    .Width(DATA_WIDTH),
    .AddrW(AddrW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_count_o = count_q;
  assign out_value_o   = oval_q;
  assign out_index_o   = oidx_q;
  assign is_last_o     = last_q;

endmodule
